// ===== rtl/core/sparse_poly_add_merge_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sparse polynomial adder.
// They are clocked by clk and quiet while rst is high, unless noted.
// ---------------------------------------------------------------------------
`ifndef SPARSE_POLY_ADD_MERGE_DEFINES_SVH
`define SPARSE_POLY_ADD_MERGE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only outside reset.
`define SPADD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define SPADD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPADD_ASSERT(lbl, prop, msg)
`define SPADD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/spadd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spadd_pkg
// Item types and codes shared by the sparse polynomial adder.
// ---------------------------------------------------------------------------
package spadd_pkg;

  localparam int COEFF_W = 32;
  localparam int EXPO_W  = 10;
  localparam int TERM_W  = COEFF_W + EXPO_W;

  // Item kinds.
  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_SECOND = 2'd1;
  localparam logic [1:0] KIND_MERGE  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_SUM   = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [COEFF_W-1:0] coeff;
    logic [EXPO_W-1:0]         expo;
  } req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [COEFF_W-1:0] sum_coeff;
    logic [EXPO_W-1:0]         sum_expo;
    logic                      last;
  } rsp_t;

endpackage

// ===== rtl/core/spadd_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spadd_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module spadd_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sparse_poly_add_merge.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sparse_poly_add_merge
// Adds two sparse polynomials by merging two exponent-sorted term lists.
// ---------------------------------------------------------------------------
// Terms are loaded one item at a time (kind 0 to the first list, kind 1 to
// the second), a load giving no result unless the list already holds
// MAX_TERMS terms, in which case the term is dropped and one full-status
// result comes back. A kind 2 item runs the merge: for every result term,
// state S_FETCH reads the heads of both lists from their term RAMs
// (registered read) and state S_EMIT compares, adds with saturation and
// loads the output register, waiting there while the output is stalled. A
// merge gives at most 2 * MAX_TERMS results, the last one marked, and then
// empties both lists; if either list is empty it gives one insufficient-
// status result instead. No new item is taken while a merge runs.
`include "sparse_poly_add_merge_defines.svh"

module sparse_poly_add_merge #(
  parameter int MAX_TERMS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  spadd_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output spadd_pkg::rsp_t  rsp
);
  import spadd_pkg::*;

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TERMS);
  localparam logic signed [COEFF_W-1:0] Q_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
  localparam logic signed [COEFF_W-1:0] Q_MIN = {1'b1, {(COEFF_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t          state;
  logic [CW-1:0]   cnt_a, cnt_b;
  logic [CW-1:0]   idx_a, idx_b;
  logic [CW-1:0]   idx_a_next, idx_b_next;
  logic            req_fire, out_free;
  logic            rsp_load, merge_end;
  logic            wr_a, wr_b;
  logic [TERM_W-1:0] wdata;
  logic [TERM_W-1:0] rdata_a, rdata_b;

  logic signed [COEFF_W-1:0] pc, qc, sat, m_coeff;
  logic [EXPO_W-1:0]         pe, qe, m_expo;
  logic signed [COEFF_W:0]   sum_wide;
  logic has_a, has_b, take_a, take_b, done;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && out_free;
  assign req_fire  = req_valid && req_ready;

  assign wr_a  = req_fire && (req.kind == KIND_FIRST) && (cnt_a < CNT_MAX);
  assign wr_b  = req_fire && (req.kind == KIND_SECOND) && (cnt_b < CNT_MAX);
  assign wdata = {req.expo, req.coeff};

  spadd_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_ram_a (
    .clk   (clk),
    .we    (wr_a),
    .waddr (cnt_a[AW-1:0]),
    .wdata (wdata),
    .raddr (idx_a[AW-1:0]),
    .rdata (rdata_a)
  );

  spadd_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_ram_b (
    .clk   (clk),
    .we    (wr_b),
    .waddr (cnt_b[AW-1:0]),
    .wdata (wdata),
    .raddr (idx_b[AW-1:0]),
    .rdata (rdata_b)
  );

  assign pc = rdata_a[COEFF_W-1:0];
  assign pe = rdata_a[TERM_W-1:COEFF_W];
  assign qc = rdata_b[COEFF_W-1:0];
  assign qe = rdata_b[TERM_W-1:COEFF_W];

  // Head selection: equal exponents consume both heads, otherwise the
  // larger exponent passes; once one list runs out the other drains.
  always_comb begin
    has_a  = idx_a < cnt_a;
    has_b  = idx_b < cnt_b;
    take_a = 1'b0;
    take_b = 1'b0;
    if (has_a && has_b) begin
      if (pe == qe) begin
        take_a = 1'b1;
        take_b = 1'b1;
      end else if (pe > qe) begin
        take_a = 1'b1;
      end else begin
        take_b = 1'b1;
      end
    end else if (has_a) begin
      take_a = 1'b1;
    end else begin
      take_b = 1'b1;
    end
  end

  assign sum_wide = {pc[COEFF_W-1], pc} + {qc[COEFF_W-1], qc};

  always_comb begin
    if (sum_wide[COEFF_W] != sum_wide[COEFF_W-1]) begin
      sat = sum_wide[COEFF_W] ? Q_MIN : Q_MAX;
    end else begin
      sat = sum_wide[COEFF_W-1:0];
    end
  end

  assign m_coeff    = (take_a && take_b) ? sat : (take_a ? pc : qc);
  assign m_expo     = take_a ? pe : qe;
  assign idx_a_next = idx_a + CW'(take_a);
  assign idx_b_next = idx_b + CW'(take_b);
  assign done       = (idx_a_next == cnt_a) && (idx_b_next == cnt_b);
  assign merge_end  = (state == S_EMIT) && out_free && done;

  // The output register is loaded by a merge term, a full load or a merge
  // with an empty list.
  always_comb begin
    rsp_load = 1'b0;
    if (state == S_EMIT) begin
      rsp_load = out_free;
    end else if (req_fire) begin
      if (req.kind inside {KIND_FIRST, KIND_SECOND}) begin
        rsp_load = !wr_a && !wr_b;
      end else if (req.kind == KIND_MERGE) begin
        rsp_load = (cnt_a == '0) || (cnt_b == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt_a     <= '0;
      cnt_b     <= '0;
      idx_a     <= '0;
      idx_b     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_load || (rsp_valid && !rsp_ready);
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            case (req.kind)
              KIND_FIRST, KIND_SECOND: begin
                if (wr_a) begin
                  cnt_a <= cnt_a + CW'(1);
                end else if (wr_b) begin
                  cnt_b <= cnt_b + CW'(1);
                end else begin
                  rsp <= '{status: ST_FULL, sum_coeff: '0, sum_expo: '0, last: 1'b1};
                end
              end
              KIND_MERGE: begin
                if (cnt_a == '0 || cnt_b == '0) begin
                  rsp <= '{status: ST_SHORT, sum_coeff: '0, sum_expo: '0, last: 1'b1};
                end else begin
                  idx_a <= '0;
                  idx_b <= '0;
                  state <= S_FETCH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FETCH: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            rsp <= '{status: ST_SUM, sum_coeff: m_coeff, sum_expo: m_expo, last: done};
            if (done) begin
              idx_a <= '0;
              idx_b <= '0;
              cnt_a <= '0;
              cnt_b <= '0;
              state <= S_IDLE;
            end else begin
              idx_a <= idx_a_next;
              idx_b <= idx_b_next;
              state <= S_FETCH;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SPADD_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE) && !rsp_valid, "reset left block busy")
  `SPADD_ASSERT(a_cnt_bound, (cnt_a <= CNT_MAX) && (cnt_b <= CNT_MAX), "list count past capacity")
  `SPADD_ASSERT(a_idx_bound, (idx_a <= cnt_a) && (idx_b <= cnt_b), "merge index past list end")
  `SPADD_ASSERT(a_emit_has_term, (state == S_EMIT) |-> (has_a || has_b), "emit with no term left")
  `SPADD_ASSERT(a_merge_end, merge_end |=> (cnt_a == '0) && (cnt_b == '0) && rsp.last, "lists kept")

endmodule
